>>> rtl/core/scancode_to_ascii_decoder_macros.svh
// assertion macros for the scancode decoder
// used by scancode_to_ascii_decoder.sv, no other dependencies
`ifndef SCANCODE_TO_ASCII_DECODER_MACROS_SVH
`define SCANCODE_TO_ASCII_DECODER_MACROS_SVH

`ifndef ASSERT_OFF

// check on every rising edge outside reset
`define SC2A_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every rising edge, reset included
`define SC2A_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SC2A_ASSERT(label, clk, rst, prop, msg)
`define SC2A_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

>>> rtl/core/sc2a_pkg.sv
// shared types, key codes and lookup tables of the scancode decoder
// no dependencies
`timescale 1ns / 1ps

package sc2a_pkg;

  // scancode framing
  localparam logic [7:0] RELEASE_BIT  = 8'h80;
  localparam logic [7:0] MAKE_LIMIT   = 8'h53;
  localparam logic [7:0] BREAK_LSHIFT = 8'hAA;
  localparam logic [7:0] BREAK_RSHIFT = 8'hB6;

  // special key codes held in the normal table
  localparam logic [6:0] KEY_NONE   = 7'h00;
  localparam logic [6:0] KEY_ESC    = 7'h01;
  localparam logic [6:0] KEY_LSHIFT = 7'h03;
  localparam logic [6:0] KEY_RSHIFT = 7'h04;
  localparam logic [6:0] KEY_CAPS   = 7'd14;
  localparam logic [6:0] KEY_NUM    = 7'd15;
  localparam logic [6:0] KEY_SCROLL = 7'd16;

  // ascii codes with special handling
  localparam logic [6:0] ASCII_BS      = 7'h08;
  localparam logic [6:0] ASCII_TAB     = 7'h09;
  localparam logic [6:0] ASCII_LF      = 7'h0A;
  localparam logic [6:0] ASCII_SPACE   = 7'h20;
  localparam logic [6:0] ASCII_LOWER_A = 7'h61;
  localparam logic [6:0] ASCII_LOWER_Z = 7'h7A;

  localparam int ROM_DEPTH = 82;

  // keyboard flag set
  typedef struct packed {
    logic lshift;
    logic rshift;
    logic caps;
    logic num;
    logic scroll;
  } sc2a_flags_t;

  // unshifted key table, indexed by make code minus one
  localparam logic [6:0] NORMAL_ROM [0:ROM_DEPTH-1] = '{
    7'h01,
    7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D,
    7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D,
    7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B, 7'h27, 7'h60,
    7'h03, 7'h5C,
    7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F,
    7'h04, 7'h2A, 7'h00, 7'h20, 7'h0E,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h0F, 7'h10,
    7'h37, 7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31, 7'h32, 7'h33, 7'h30
  };

  // shifted key table, same indexing
  localparam logic [6:0] SHIFTED_ROM [0:ROM_DEPTH-1] = '{
    7'h00,
    7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B,
    7'h00, 7'h00,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D,
    7'h00, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A, 7'h22, 7'h7E,
    7'h00, 7'h7C,
    7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F,
    7'h00, 7'h2A, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00,
    7'h37, 7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31, 7'h32, 7'h33, 7'h30
  };

endpackage

>>> rtl/core/scancode_to_ascii_decoder.sv
// set-1 scancode to ascii decoder, top level
// depends on sc2a_pkg and scancode_to_ascii_decoder_macros.svh
`timescale 1ns / 1ps

// Takes one raw set-1 scancode byte per item and returns one result item per
// scancode: an ascii character with its valid flag, an escape reboot request,
// and the caps, num and scroll lock flags as they stand after that scancode.
// Shift and lock flags are kept inside and updated in scancode order. The
// block accepts one item every cycle while the output side takes results;
// each item passes through the input register and the result register,
// with the table lookup and flag update between them. A stalled output holds
// its result and backs up the input side after one more item.
module scancode_to_ascii_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] scancode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [6:0] char_code, [7] reboot_request, [8] led_caps,
                                      // [9] led_num, [10] led_scroll, [15:11] zero
  output logic        m_axis_tuser    // [0] char_valid
);

`include "scancode_to_ascii_decoder_macros.svh"

  // input register
  logic       s1_valid;
  logic [7:0] s1_code;

  // result register
  logic       out_char_valid;
  logic [6:0] out_char_code;
  logic       out_reboot;
  logic       out_caps;
  logic       out_num;
  logic       out_scroll;

  // keyboard state
  sc2a_pkg::sc2a_flags_t flags;
  sc2a_pkg::sc2a_flags_t flags_next;

  // decode results
  logic       char_valid_next;
  logic [6:0] char_code_next;
  logic       reboot_next;

  logic       out_ready;
  logic       advance;
  logic       is_make;
  logic [6:0] rom_idx;
  logic [6:0] key;
  logic [6:0] key_shifted;
  logic       shift_any;
  logic       use_shift;

  // pipeline flow control
  assign out_ready     = !m_axis_tvalid || m_axis_tready;
  assign advance       = s1_valid && out_ready;
  assign s_axis_tready = !s1_valid || out_ready;

  // table lookup
  assign is_make = ((s1_code & sc2a_pkg::RELEASE_BIT) == 8'h00) && (s1_code != 8'h00) &&
                   (s1_code < sc2a_pkg::MAKE_LIMIT);
  assign rom_idx     = is_make ? (s1_code[6:0] - 7'd1) : 7'd0;
  assign key         = sc2a_pkg::NORMAL_ROM[rom_idx];
  assign key_shifted = sc2a_pkg::SHIFTED_ROM[rom_idx];
  assign shift_any   = flags.lshift || flags.rshift;

  // letters follow shift xor caps, other printables follow shift
  always_comb begin
    if (key >= sc2a_pkg::ASCII_LOWER_A && key <= sc2a_pkg::ASCII_LOWER_Z) begin
      use_shift = shift_any ^ flags.caps;
    end else begin
      use_shift = shift_any;
    end
  end

  // key action and flag update
  always_comb begin
    flags_next      = flags;
    char_valid_next = 1'b0;
    char_code_next  = sc2a_pkg::KEY_NONE;
    reboot_next     = 1'b0;
    if (is_make) begin
      if (key == sc2a_pkg::KEY_ESC) begin
        reboot_next = 1'b1;
      end else if (key > sc2a_pkg::ASCII_SPACE) begin
        char_valid_next = 1'b1;
        char_code_next  = use_shift ? key_shifted : key;
      end else if (key == sc2a_pkg::KEY_CAPS) begin
        flags_next.caps = !flags.caps;
      end else if (key == sc2a_pkg::KEY_NUM) begin
        flags_next.num = !flags.num;
      end else if (key == sc2a_pkg::KEY_SCROLL) begin
        flags_next.scroll = !flags.scroll;
      end else if (key == sc2a_pkg::ASCII_LF || key == sc2a_pkg::ASCII_TAB ||
                   key == sc2a_pkg::ASCII_BS || key == sc2a_pkg::ASCII_SPACE) begin
        char_valid_next = 1'b1;
        char_code_next  = key;
      end else if (key == sc2a_pkg::KEY_LSHIFT) begin
        flags_next.lshift = 1'b1;
      end else if (key == sc2a_pkg::KEY_RSHIFT) begin
        flags_next.rshift = 1'b1;
      end
    end else if (s1_code == sc2a_pkg::BREAK_LSHIFT) begin
      flags_next.lshift = 1'b0;
      flags_next.rshift = 1'b0;
    end else if (s1_code == sc2a_pkg::BREAK_RSHIFT) begin
      flags_next.rshift = 1'b0;
    end
  end

  // control state and keyboard flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      flags         <= '0;
    end else begin
      if (s_axis_tready) begin
        s1_valid <= s_axis_tvalid;
      end
      if (out_ready) begin
        m_axis_tvalid <= s1_valid;
      end
      if (advance) begin
        flags <= flags_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_code <= s_axis_tdata;
    end
    if (advance) begin
      out_char_valid <= char_valid_next;
      out_char_code  <= char_code_next;
      out_reboot     <= reboot_next;
      out_caps       <= flags_next.caps;
      out_num        <= flags_next.num;
      out_scroll     <= flags_next.scroll;
    end
  end

  // result item packing
  assign m_axis_tdata = {5'b00000, out_scroll, out_num, out_caps, out_reboot, out_char_code};
  assign m_axis_tuser = out_char_valid;

  // checks
  `SC2A_ASSERT(a_code_matches_valid, clk, rst,
    m_axis_tvalid |-> (out_char_valid == (out_char_code != 7'd0)),
    "char code and char valid disagree")
  `SC2A_ASSERT(a_reboot_no_char, clk, rst,
    m_axis_tvalid |-> !(out_reboot && out_char_valid),
    "reboot request together with a character")
  `SC2A_ASSERT(a_flags_hold_when_idle, clk, rst,
    !advance |=> $stable(flags),
    "keyboard flags changed without a decoded item")
  `SC2A_ASSERT(a_ready_when_empty, clk, rst,
    !m_axis_tvalid |-> s_axis_tready,
    "input stalled while the result register is empty")

endmodule
